@@ hdl/hmvn_pkg.sv @@
package hmvn_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int HEIGHT_W   = 16;
    localparam int NORM_W     = 16;
    localparam int NORMY_W    = 15;
    localparam int POS_W      = 10;
    localparam int TDATA_W    = 72;

    localparam int FACE_W     = HEIGHT_W + 1;
    localparam int SUM_W      = FACE_W + 2;
    localparam int Y_W        = 11;
    localparam int MAG_W      = SUM_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SQ_SUM_W   = SQ_W + 2;
    localparam int Q_W        = 15;
    localparam int ACC_W      = 76;
    localparam int Y_UNIT     = 256;

    localparam logic [CFG_W-1:0] RESET_COLUMNS = CFG_W'(256);
    localparam logic [CFG_W-1:0] RESET_ROWS    = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);

    typedef struct packed {
        logic accept;
        logic read_next;
        logic face;
        logic square;
        logic start;
        logic load;
        logic second;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic two;
        logic done;
        logic out_free;
    } status_t;

endpackage

@@ hdl/hmvn_scale.sv @@
module hmvn_scale (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [hmvn_pkg::MAG_W-1:0]     mag,
    input  logic [hmvn_pkg::SQ_SUM_W-1:0]  sqsum,
    output logic                           done,
    output logic [hmvn_pkg::Q_W-1:0]       q
);

    localparam int AW  = hmvn_pkg::ACC_W;
    localparam int KW  = $clog2(hmvn_pkg::Q_W);
    localparam int RSH = 2 * hmvn_pkg::Q_W;

    logic                          busy_reg, prep_reg, phase_reg, done_reg;
    logic [KW-1:0]                 k_reg;
    logic [hmvn_pkg::Q_W-1:0]      q_reg;
    logic [hmvn_pkg::MAG_W-1:0]    m_reg;
    logic [AW-1:0]                 s_reg, a_reg, b_reg, ca_reg, cb_reg, rr_reg;
    logic [hmvn_pkg::SQ_W-1:0]     mm;
    logic [AW-1:0]                 tst;

    assign mm  = m_reg * m_reg;
    // (2q-1)^2 * s for the candidate, from the incremental terms
    assign tst = ca_reg - (cb_reg << 1) + s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            prep_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                prep_reg  <= 1'b1;
                phase_reg <= 1'b0;
                m_reg     <= mag;
                s_reg     <= AW'(sqsum);
                q_reg     <= '0;
                a_reg     <= '0;
                b_reg     <= '0;
                k_reg     <= KW'(hmvn_pkg::Q_W - 1);
            end else if (busy_reg) begin
                if (prep_reg) begin
                    rr_reg   <= AW'(mm) << RSH;
                    prep_reg <= 1'b0;
                end else if (!phase_reg) begin
                    ca_reg    <= a_reg + (b_reg << (k_reg + 5'd2))
                                 + (s_reg << ({k_reg, 1'b0} + 5'd2));
                    cb_reg    <= b_reg + (s_reg << (k_reg + 5'd1));
                    phase_reg <= 1'b1;
                end else begin
                    phase_reg <= 1'b0;
                    if (tst <= rr_reg) begin
                        a_reg        <= ca_reg;
                        b_reg        <= cb_reg;
                        q_reg[k_reg] <= 1'b1;
                    end
                    if (k_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        k_reg <= k_reg - KW'(1);
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

@@ hdl/hmvn_datapath.sv @@
module hmvn_datapath #(
    parameter int MAX_COLUMNS = hmvn_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = hmvn_pkg::DEF_MAX_ROWS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hmvn_pkg::cmd_t                     cmd,
    output hmvn_pkg::status_t                  status,
    input  logic signed [hmvn_pkg::HEIGHT_W-1:0] height_sample,
    input  logic                               cfg_write,
    input  logic [hmvn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmvn_pkg::CFG_W-1:0]         cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hmvn_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CFW = (CW + 1 > hmvn_pkg::CFG_W) ? CW + 1 : hmvn_pkg::CFG_W;
    localparam int RFW = (RW + 1 > hmvn_pkg::CFG_W) ? RW + 1 : hmvn_pkg::CFG_W;
    localparam int FW  = hmvn_pkg::FACE_W;
    localparam int SW  = hmvn_pkg::SUM_W;
    localparam int HW  = hmvn_pkg::HEIGHT_W;

    logic [hmvn_pkg::CFG_W-1:0] cols_cfg_reg, rows_cfg_reg;
    logic [CW:0]                cols;
    logic [RW:0]                rows;
    logic [CFW-1:0]             cols_wide;
    logic [RFW-1:0]             rows_wide;

    logic [CW-1:0] cnt_c_reg, c_reg, c_eff;
    logic [RW-1:0] cnt_r_reg, r_reg, r_eff;
    logic signed [HW-1:0] h_reg, a_reg, ht_q;
    logic [2*FW-1:0]      uf_q;
    logic signed [HW-1:0] heights [MAX_COLUMNS];
    logic [2*FW-1:0]      faces   [MAX_COLUMNS];
    logic [CW-1:0]        ht_addr;

    logic signed [FW-1:0] left_x_reg, left_z_reg, diag_x_reg, diag_z_reg;
    logic signed [FW-1:0] fx, fz, ux, uz;
    logic                 has_face, has_left, deep;
    logic                 last_row, last_col;

    logic signed [SW-1:0] v1x, v1z, v2x, v2z;
    logic signed [SW-1:0] v1x_reg, v1z_reg, v2x_reg, v2z_reg;
    logic [2:0]           n1, n2;
    logic [hmvn_pkg::Y_W-1:0] v1y_reg, v2y_reg;
    logic                 last_v2_reg;

    logic signed [SW-1:0]      sx, sz;
    logic [hmvn_pkg::MAG_W-1:0] mx, my, mz, mx_reg, my_reg, mz_reg;
    logic                      negx_reg, negz_reg;
    logic [hmvn_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [hmvn_pkg::SQ_SUM_W-1:0] sqsum;
    logic                      dx, dy, dz;
    logic [hmvn_pkg::Q_W-1:0]  qx, qy, qz;

    logic                          out_valid_reg, out_last_reg;
    logic [hmvn_pkg::NORM_W-1:0]   out_nx_reg, out_nz_reg;
    logic [hmvn_pkg::NORMY_W-1:0]  out_ny_reg;
    logic [hmvn_pkg::POS_W-1:0]    out_col_reg, out_row_reg;

    // clamp sizes to [2, max]
    always_comb begin
        cols_wide = CFW'(cols_cfg_reg);
        rows_wide = RFW'(rows_cfg_reg);
        if (cols_wide < CFW'(2))                cols_wide = CFW'(2);
        else if (cols_wide > CFW'(MAX_COLUMNS)) cols_wide = CFW'(MAX_COLUMNS);
        if (rows_wide < RFW'(2))                rows_wide = RFW'(2);
        else if (rows_wide > RFW'(MAX_ROWS))    rows_wide = RFW'(MAX_ROWS);
        cols   = cols_wide[CW:0];
        rows   = rows_wide[RW:0];
    end

    always_comb begin
        if ((CW + 1)'(cnt_c_reg) >= cols || (RW + 1)'(cnt_r_reg) >= rows) begin
            c_eff = '0;
            r_eff = '0;
        end else begin
            c_eff = cnt_c_reg;
            r_eff = cnt_r_reg;
        end
    end

    assign ht_addr = cmd.accept ? c_eff : c_reg + CW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.accept || cmd.read_next) ht_q <= heights[ht_addr];
        if (cmd.face) heights[c_reg] <= h_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_next) uf_q <= faces[c_reg];
        if (cmd.face && has_face && r_reg != '0) faces[c_reg] <= {fz, fx};
    end

    assign has_face = (CW + 1)'(c_reg) + (CW + 1)'(1) < cols;
    assign has_left = c_reg != '0;
    assign deep     = r_reg > RW'(1);
    assign last_row = (RW + 1)'(r_reg) + (RW + 1)'(1) == rows;
    assign last_col = (CW + 1)'(c_reg) + (CW + 1)'(1) == cols;
    assign fx = has_face ? FW'(a_reg) - FW'(ht_q) : '0;
    assign fz = has_face ? FW'(a_reg) - FW'(h_reg) : '0;
    assign ux = uf_q[FW-1:0];
    assign uz = uf_q[2*FW-1:FW];

    always_comb begin
        v2x = SW'(fx);
        v2z = SW'(fz);
        n2  = has_face ? 3'd1 : 3'd0;
        if (has_left) begin
            v2x = v2x + SW'(left_x_reg);
            v2z = v2z + SW'(left_z_reg);
            n2  = n2 + 3'd1;
        end
        v1x = v2x;
        v1z = v2z;
        n1  = n2;
        if (deep && has_left) begin
            v1x = v1x + SW'(diag_x_reg);
            v1z = v1z + SW'(diag_z_reg);
            n1  = n1 + 3'd1;
        end
        if (deep && has_face) begin
            v1x = v1x + SW'(ux);
            v1z = v1z + SW'(uz);
            n1  = n1 + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= hmvn_pkg::RESET_COLUMNS;
            rows_cfg_reg <= hmvn_pkg::RESET_ROWS;
            cnt_c_reg    <= '0;
            cnt_r_reg    <= '0;
            left_x_reg   <= '0;
            left_z_reg   <= '0;
            diag_x_reg   <= '0;
            diag_z_reg   <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    hmvn_pkg::REG_GRID_COLUMNS: begin
                        cols_cfg_reg <= cfg_data;
                        cnt_c_reg    <= '0;
                        cnt_r_reg    <= '0;
                    end
                    hmvn_pkg::REG_GRID_ROWS: begin
                        rows_cfg_reg <= cfg_data;
                        cnt_c_reg    <= '0;
                        cnt_r_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.face) begin
                if (r_reg != '0) begin
                    diag_x_reg <= ux;
                    diag_z_reg <= uz;
                    left_x_reg <= fx;
                    left_z_reg <= fz;
                end
                if (last_col) begin
                    cnt_c_reg <= '0;
                    cnt_r_reg <= last_row ? '0 : r_reg + RW'(1);
                end else begin
                    cnt_c_reg <= c_reg + CW'(1);
                    cnt_r_reg <= r_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            h_reg <= height_sample;
            c_reg <= c_eff;
            r_reg <= r_eff;
        end
        if (cmd.read_next) a_reg <= ht_q;
        if (cmd.face) begin
            v1x_reg     <= v1x;
            v1z_reg     <= v1z;
            v2x_reg     <= v2x;
            v2z_reg     <= v2z;
            v1y_reg     <= hmvn_pkg::Y_W'(n1) * hmvn_pkg::Y_W'(hmvn_pkg::Y_UNIT);
            v2y_reg     <= hmvn_pkg::Y_W'(n2) * hmvn_pkg::Y_W'(hmvn_pkg::Y_UNIT);
            last_v2_reg <= last_col;
        end
    end

    assign sx = cmd.second ? v2x_reg : v1x_reg;
    assign sz = cmd.second ? v2z_reg : v1z_reg;
    assign mx = sx[SW-1] ? hmvn_pkg::MAG_W'(-sx) : hmvn_pkg::MAG_W'(sx);
    assign mz = sz[SW-1] ? hmvn_pkg::MAG_W'(-sz) : hmvn_pkg::MAG_W'(sz);
    assign my = hmvn_pkg::MAG_W'(cmd.second ? v2y_reg : v1y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            mx_reg   <= mx;
            my_reg   <= my;
            mz_reg   <= mz;
            negx_reg <= sx[SW-1];
            negz_reg <= sz[SW-1];
            sqx_reg  <= mx * mx;
            sqy_reg  <= my * my;
            sqz_reg  <= mz * mz;
        end
    end

    assign sqsum = hmvn_pkg::SQ_SUM_W'(sqx_reg) + hmvn_pkg::SQ_SUM_W'(sqy_reg)
                 + hmvn_pkg::SQ_SUM_W'(sqz_reg);

    hmvn_scale u_scale_x (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .mag(mx_reg), .sqsum(sqsum), .done(dx), .q(qx));
    hmvn_scale u_scale_y (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .mag(my_reg), .sqsum(sqsum), .done(dy), .q(qy));
    hmvn_scale u_scale_z (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .mag(mz_reg), .sqsum(sqsum), .done(dz), .q(qz));

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_nx_reg   <= negx_reg ? hmvn_pkg::NORM_W'(-{1'b0, qx})
                                     : hmvn_pkg::NORM_W'(qx);
            out_nz_reg   <= negz_reg ? hmvn_pkg::NORM_W'(-{1'b0, qz})
                                     : hmvn_pkg::NORM_W'(qz);
            out_ny_reg   <= hmvn_pkg::NORMY_W'(qy);
            out_col_reg  <= hmvn_pkg::POS_W'(c_reg);
            out_row_reg  <= cmd.second ? hmvn_pkg::POS_W'(r_reg)
                                       : hmvn_pkg::POS_W'(r_reg - RW'(1));
            out_last_reg <= cmd.second && last_v2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = hmvn_pkg::TDATA_W'({out_row_reg, out_col_reg, out_nz_reg,
                                          out_ny_reg, out_nx_reg});

    assign status.emit     = r_reg != '0;
    assign status.two      = last_row;
    assign status.done     = dx && dy && dz;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

@@ hdl/hmvn_ctrl.sv @@
module hmvn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hmvn_pkg::status_t status,
    output hmvn_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_FACE, ST_SQUARE, ST_START, ST_WAIT, ST_LOAD
    } state_t;

    state_t state_reg;
    logic   second_reg;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        cmd           = '0;
        cmd.second    = second_reg;
        cmd.accept    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.read_next = state_reg == ST_READ;
        cmd.face      = state_reg == ST_FACE;
        cmd.square    = state_reg == ST_SQUARE;
        cmd.start     = state_reg == ST_START;
        cmd.load      = (state_reg == ST_LOAD) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE:   if (s_tvalid) state_reg <= ST_READ;
                ST_READ:   state_reg <= ST_FACE;
                ST_FACE: begin
                    second_reg <= 1'b0;
                    state_reg  <= status.emit ? ST_SQUARE : ST_IDLE;
                end
                ST_SQUARE: state_reg <= ST_START;
                ST_START:  state_reg <= ST_WAIT;
                ST_WAIT:   if (status.done) state_reg <= ST_LOAD;
                ST_LOAD: begin
                    if (status.out_free) begin
                        if (!second_reg && status.two) begin
                            second_reg <= 1'b1;
                            state_reg  <= ST_SQUARE;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/heightmap_vertex_normals.sv @@
// channel   direction  handshake                 payload
// s_        in         s_tvalid / s_tready       height_sample
// m_        out        m_tvalid / m_tready       normals, position, tlast
// cfg_      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a sample in the first row emits nothing, any other sample emits one normal,
// and a sample in the last row emits a second normal
// three bit-serial scaling units, one per component, run side by side; after a
// setup step, each of the 15 result bits takes a candidate step and a compare step
// aresetn is synchronous, active low; grid size returns to 256 x 256
// a finished word waits in the output register; the next normal of a last-row
// sample is computed meanwhile and held until that word is taken
module heightmap_vertex_normals #(
    parameter int MAX_COLUMNS = hmvn_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = hmvn_pkg::DEF_MAX_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] height_sample
    input  logic [15:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] normal_x, [30:16] normal_y, [46:31] normal_z,
    // [56:47] vertex_column, [66:57] vertex_row, rest zero
    output logic [hmvn_pkg::TDATA_W-1:0]        m_tdata,
    // last_of_grid
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hmvn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hmvn_pkg::CFG_W-1:0]          cfg_data
);

    hmvn_pkg::cmd_t    cmd;
    hmvn_pkg::status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    hmvn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hmvn_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .height_sample (s_tdata),
        .cfg_write     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule
